// ----- rtl/bhrp_pkg.sv -----
// Shared types, reset values and command codes for the button hold relay panel.
package bhrp_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int AGE_W           = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int CODE_W          = 4;
	localparam int NUM_BTN         = 3;

	localparam logic [CFG_W-1:0] HOLD_MIN_RST   = 16'd1000;
	localparam logic [CFG_W-1:0] LONG_HOLD_RST  = 16'd3000;
	localparam logic [CFG_W-1:0] BUZZER_LEN_RST = 16'd500;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUZZER_LEN = 2'd2;

	// command codes, shared by the remote path and the buttons
	localparam logic [CODE_W-1:0] CMD_SCREEN = 4'd1;
	localparam logic [CODE_W-1:0] CMD_AUTO   = 4'd2;
	localparam logic [CODE_W-1:0] CMD_SELECT = 4'd3;
	localparam logic [CODE_W-1:0] CMD_SWITCH = 4'd4;

	// button order in the level and hold arrays
	localparam int BTN_SCREEN = 0;
	localparam int BTN_SELECT = 1;
	localparam int BTN_SWITCH = 2;

	typedef struct packed {
		logic [CFG_W-1:0] hold_min;
		logic [CFG_W-1:0] long_hold;
		logic [CFG_W-1:0] buzzer_len;
	} cfg_t;

	typedef struct packed {
		logic              screen_mode;
		logic              auto_mode;
		logic              selected_relay;
		logic              relay_one;
		logic              relay_two;
		logic              lamp_one;
		logic              lamp_two;
		logic              buzzer_on;
		logic [CODE_W-1:0] cmd_mask;
	} result_t;

endpackage

// ----- rtl/bhrp_button.sv -----
// Edge detect and saturating hold counter for one active-low button.
module bhrp_button #(
	parameter int COUNT_WIDTH = bhrp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   level,
	output logic                   released,
	output logic [COUNT_WIDTH-1:0] held
);
	import bhrp_pkg::*;

	logic                   prev_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   was_pressed;
	logic                   is_pressed;
	logic [COUNT_WIDTH-1:0] count_inc;

	assign was_pressed = !prev_q;
	assign is_pressed  = !level;
	assign released    = was_pressed && !is_pressed;

	// saturate at all ones; a press edge restarts the count
	always_comb begin
		count_inc = count_q;
		if (was_pressed && (count_q != {COUNT_WIDTH{1'b1}}))
			count_inc = count_q + COUNT_WIDTH'(1);
		held = (is_pressed && !was_pressed) ? '0 : count_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b1;
			count_q <= '0;
		end else if (advance) begin
			prev_q  <= level;
			count_q <= held;
		end
	end

endmodule

// ----- rtl/bhrp_panel.sv -----
// Command decode, mode/relay/lamp state and buzzer timer of the panel.
module bhrp_panel #(
	parameter int COUNT_WIDTH = bhrp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            advance,
	input  bhrp_pkg::cfg_t                                  cfg,
	input  logic [bhrp_pkg::NUM_BTN-1:0]                    released,
	input  logic [bhrp_pkg::NUM_BTN-1:0][COUNT_WIDTH-1:0]   held,
	input  logic                                            remote_valid,
	input  logic [bhrp_pkg::CODE_W-1:0]                     remote_button,
	output bhrp_pkg::result_t                               result
);
	import bhrp_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic [2:0]       mode_q;
	logic [1:0]       relay_q;
	logic [1:0]       lamp_q;
	logic             buzz_q;
	logic [AGE_W-1:0] age_q;

	logic [2:0]       mode_d;
	logic [1:0]       relay_d;
	logic [1:0]       lamp_d;
	logic             buzz_d;
	logic [AGE_W-1:0] age_d;

	logic [NUM_BTN-1:0][CMP_W-1:0] held_x;
	logic [CMP_W-1:0] hold_min_x;
	logic [CMP_W-1:0] long_hold_x;
	logic             btn_screen;
	logic             btn_auto;
	logic             btn_select;
	logic             btn_switch;
	logic             rem_screen;
	logic             rem_auto;
	logic             rem_select;
	logic             rem_switch;
	logic             any_cmd;
	logic [CODE_W-1:0] mask;

	always_comb begin
		for (int b = 0; b < NUM_BTN; b++)
			held_x[b] = CMP_W'(held[b]);
	end

	assign hold_min_x  = CMP_W'(cfg.hold_min);
	assign long_hold_x = CMP_W'(cfg.long_hold);

	// decode the press windows; equal to a bound gives nothing
	assign btn_screen = released[BTN_SCREEN] && (held_x[BTN_SCREEN] > hold_min_x)
		&& (held_x[BTN_SCREEN] < long_hold_x);
	assign btn_auto   = released[BTN_SCREEN] && !btn_screen
		&& (held_x[BTN_SCREEN] > long_hold_x);
	assign btn_select = released[BTN_SELECT] && (held_x[BTN_SELECT] > hold_min_x)
		&& (held_x[BTN_SELECT] < long_hold_x);
	assign btn_switch = released[BTN_SWITCH] && (held_x[BTN_SWITCH] > hold_min_x);

	assign rem_screen = remote_valid && (remote_button == CMD_SCREEN);
	assign rem_auto   = remote_valid && (remote_button == CMD_AUTO);
	assign rem_select = remote_valid && (remote_button == CMD_SELECT);
	assign rem_switch = remote_valid && (remote_button == CMD_SWITCH);

	assign any_cmd = remote_valid || btn_screen || btn_auto || btn_select || btn_switch;
	assign mask    = {rem_switch || btn_switch, rem_select || btn_select,
		rem_auto || btn_auto, rem_screen || btn_screen};

	// apply in order remote, then buttons; the same toggle twice cancels
	always_comb begin
		mode_d  = mode_q;
		relay_d = relay_q;
		lamp_d  = lamp_q;
		mode_d[0] = mode_q[0] ^ rem_screen ^ btn_screen;
		mode_d[1] = mode_q[1] ^ rem_auto ^ btn_auto;
		if (rem_switch) begin
			relay_d[mode_q[2]] = !relay_d[mode_q[2]];
			lamp_d[mode_q[2]]  = !lamp_d[mode_q[2]];
		end
		mode_d[2] = mode_q[2] ^ rem_select ^ btn_select;
		if (btn_switch) begin
			relay_d[mode_d[2]] = !relay_d[mode_d[2]];
			lamp_d[mode_d[2]]  = !lamp_d[mode_d[2]];
		end

		age_d = (age_q == {AGE_W{1'b1}}) ? age_q : age_q + AGE_W'(1);
		if (any_cmd) begin
			age_d  = '0;
			buzz_d = 1'b1;
		end else begin
			buzz_d = buzz_q && !(age_d > cfg.buzzer_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			relay_q <= 2'b11;
			lamp_q  <= 2'b00;
			buzz_q  <= 1'b0;
			age_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			relay_q <= relay_d;
			lamp_q  <= lamp_d;
			buzz_q  <= buzz_d;
			age_q   <= age_d;
		end
	end

	always_comb begin
		result.screen_mode    = mode_d[0];
		result.auto_mode      = mode_d[1];
		result.selected_relay = mode_d[2];
		result.relay_one      = relay_d[0];
		result.relay_two      = relay_d[1];
		result.lamp_one       = lamp_d[0];
		result.lamp_two       = lamp_d[1];
		result.buzzer_on      = buzz_d;
		result.cmd_mask       = mask;
	end

endmodule

// ----- rtl/button_hold_relay_panel_core.sv -----
// Top level of the button hold relay panel: handshake, configuration and result register.
//
// One input transfer is one tick of the panel: three active-low button levels and an
// optional remote command code. Each tick yields exactly one result transfer carrying the
// mode flags, relay and lamp levels, buzzer drive and the mask of commands performed in that
// tick. A tick is captured in an input register, decoded by one level of compare and toggle
// logic, and written to a result register together with the panel state, from which the
// result is offered; a tick goes in on every clock and throughput is one tick per cycle,
// limited only by out_stall. in_stall rises only when the input register holds a tick that
// cannot move because the result register is full and stalled.
// Hold counters are COUNT_WIDTH bits and saturate; the buzzer age counter is 16 bits and
// saturates, so a buzzer_len of all ones keeps the buzzer on until reset. Configuration
// writes are always ready; write them only while no tick is in flight. A write to an index
// past the last register is dropped.
module button_hold_relay_panel_core #(
	parameter int COUNT_WIDTH = bhrp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tick input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             btn_screen_level,
	input  logic                             btn_select_level,
	input  logic                             btn_switch_level,
	input  logic                             remote_valid,
	input  logic [bhrp_pkg::CODE_W-1:0]      remote_button,
	// result output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             screen_mode,
	output logic                             auto_mode,
	output logic                             selected_relay,
	output logic                             relay_one,
	output logic                             relay_two,
	output logic                             lamp_one,
	output logic                             lamp_two,
	output logic                             buzzer_on,
	output logic [bhrp_pkg::CODE_W-1:0]      cmd_mask,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bhrp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bhrp_pkg::CFG_W-1:0]       cfg_data
);
	import bhrp_pkg::*;

	cfg_t                cfg_q;

	// input register
	logic                v_s1;
	logic [NUM_BTN-1:0]  levels_s1;
	logic                remote_valid_s1;
	logic [CODE_W-1:0]   remote_button_s1;

	// result register
	logic                v_s2;
	result_t             res_s2;

	logic                out_free;
	logic                advance;
	logic                in_take;
	logic [NUM_BTN-1:0]                  released;
	logic [NUM_BTN-1:0][COUNT_WIDTH-1:0] held;
	result_t             result;

	// the result register frees when empty or when its transfer completes
	assign out_free = !v_s2 || !out_stall;
	assign advance  = v_s1 && out_free;
	assign in_stall = v_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	// configuration registers; out-of-range indexes fall through and drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_min   <= HOLD_MIN_RST;
			cfg_q.long_hold  <= LONG_HOLD_RST;
			cfg_q.buzzer_len <= BUZZER_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HOLD_MIN:   cfg_q.hold_min   <= cfg_data;
				REG_LONG_HOLD:  cfg_q.long_hold  <= cfg_data;
				REG_BUZZER_LEN: cfg_q.buzzer_len <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the input register while stalled, otherwise take whatever is offered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			levels_s1        <= {btn_switch_level, btn_select_level, btn_screen_level};
			remote_valid_s1  <= remote_valid;
			remote_button_s1 <= remote_button;
		end
	end

	for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
		bhrp_button #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_button (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.level    (levels_s1[b]),
			.released (released[b]),
			.held     (held[b])
		);
	end

	bhrp_panel #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_panel (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.cfg           (cfg_q),
		.released      (released),
		.held          (held),
		.remote_valid  (remote_valid_s1),
		.remote_button (remote_button_s1),
		.result        (result)
	);

	// result register: advance when free, hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= result;
	end

	assign out_valid      = v_s2;
	assign screen_mode    = res_s2.screen_mode;
	assign auto_mode      = res_s2.auto_mode;
	assign selected_relay = res_s2.selected_relay;
	assign relay_one      = res_s2.relay_one;
	assign relay_two      = res_s2.relay_two;
	assign lamp_one       = res_s2.lamp_one;
	assign lamp_two       = res_s2.lamp_two;
	assign buzzer_on      = res_s2.buzzer_on;
	assign cmd_mask       = res_s2.cmd_mask;

endmodule

// ----- sim/tb_button_hold_relay_panel_core.sv -----
// Testbench for the button hold relay panel core: tick stimulus, panel prediction, checks.
`timescale 1ns / 100ps

module tb_button_hold_relay_panel_core;
	import bhrp_pkg::*;

	localparam int HOLD_W      = COUNT_WIDTH_DEF;
	localparam int STALL_LIMIT = 3000;   // cycles with no transfer at all before giving up
	localparam int LONG_TICKS  = 40;     // length of the long press in the long hold test

	localparam logic [HOLD_W-1:0]    HOLD_MAX   = '1;
	localparam logic [AGE_W-1:0]     AGE_MAX    = '1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // past the last register
	localparam logic [CODE_W-1:0]    CODE_NONE  = 4'd0;  // remote code that only buzzes
	localparam logic [CODE_W-1:0]    CODE_ODD   = 4'd9;  // another buzz-only remote code

	// button masks, one bit per button in level order
	localparam logic [NUM_BTN-1:0] HOLD_SCREEN = NUM_BTN'(1 << BTN_SCREEN);
	localparam logic [NUM_BTN-1:0] HOLD_SELECT = NUM_BTN'(1 << BTN_SELECT);
	localparam logic [NUM_BTN-1:0] HOLD_SWITCH = NUM_BTN'(1 << BTN_SWITCH);

	// one panel tick as offered on the input channel
	typedef struct packed {
		logic [NUM_BTN-1:0] levels;       // indexed by BTN_*, 0 pressed
		logic               remote_valid;
		logic [CODE_W-1:0]  remote_code;
	} tick_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 btn_screen_level;
	logic                 btn_select_level;
	logic                 btn_switch_level;
	logic                 remote_valid;
	logic [CODE_W-1:0]    remote_button;
	logic                 out_valid;
	logic                 out_stall;
	logic                 screen_mode;
	logic                 auto_mode;
	logic                 selected_relay;
	logic                 relay_one;
	logic                 relay_two;
	logic                 lamp_one;
	logic                 lamp_two;
	logic                 buzzer_on;
	logic [CODE_W-1:0]    cmd_mask;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// panel predictor state, mirrors what the block keeps
	cfg_t               panel_cfg;
	logic [NUM_BTN-1:0] panel_prev;
	logic [HOLD_W-1:0]  hold_ticks [NUM_BTN];
	logic               flag_screen;
	logic               flag_auto;
	logic               flag_select;
	logic [1:0]         relay_lv;
	logic [1:0]         lamp_lv;
	logic               buzz_lv;
	logic [AGE_W-1:0]   buzz_age;

	// predicted panel results, oldest first
	result_t predicted_panel [$];

	int mismatches = 0;

	// idling controls shared by the sender and the result sink
	bit src_jitter    = 1'b1;
	bit sink_jitter   = 1'b1;
	int sink_hold_req = 0;

	button_hold_relay_panel_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.btn_screen_level (btn_screen_level),
		.btn_select_level (btn_select_level),
		.btn_switch_level (btn_switch_level),
		.remote_valid     (remote_valid),
		.remote_button    (remote_button),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.screen_mode      (screen_mode),
		.auto_mode        (auto_mode),
		.selected_relay   (selected_relay),
		.relay_one        (relay_one),
		.relay_two        (relay_two),
		.lamp_one         (lamp_one),
		.lamp_two         (lamp_two),
		.buzzer_on        (buzzer_on),
		.cmd_mask         (cmd_mask),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Panel predictor
	// ------------------------------------------------------------------

	task automatic reset_panel_model;
		panel_cfg.hold_min   = HOLD_MIN_RST;
		panel_cfg.long_hold  = LONG_HOLD_RST;
		panel_cfg.buzzer_len = BUZZER_LEN_RST;
		panel_prev  = '1;
		for (int b = 0; b < NUM_BTN; b++)
			hold_ticks[b] = '0;
		flag_screen = 1'b0;
		flag_auto   = 1'b0;
		flag_select = 1'b0;
		relay_lv    = 2'b11;
		lamp_lv     = 2'b00;
		buzz_lv     = 1'b0;
		buzz_age    = '0;
	endtask

	// Apply one command: any code restarts the buzzer, known codes toggle and mark the mask.
	task automatic run_command(input logic [CODE_W-1:0] code, inout logic [CODE_W-1:0] mask);
		buzz_lv  = 1'b1;
		buzz_age = '0;
		case (code)
			CMD_SCREEN: begin
				flag_screen = !flag_screen;
				mask[CMD_SCREEN-1] = 1'b1;
			end
			CMD_AUTO: begin
				flag_auto = !flag_auto;
				mask[CMD_AUTO-1] = 1'b1;
			end
			CMD_SELECT: begin
				flag_select = !flag_select;
				mask[CMD_SELECT-1] = 1'b1;
			end
			CMD_SWITCH: begin
				// toggle whichever relay is selected, together with its lamp
				relay_lv[flag_select] = !relay_lv[flag_select];
				lamp_lv[flag_select]  = !lamp_lv[flag_select];
				mask[CMD_SWITCH-1] = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Advance the panel by one tick and produce the result the block should emit for it.
	task automatic advance_panel(input tick_t t, output result_t r);
		logic [NUM_BTN-1:0] released;
		logic [CODE_W-1:0]  mask;
		logic               was_down;
		logic               now_down;
		int                 b;
		mask = '0;
		if (buzz_age != AGE_MAX)
			buzz_age++;
		// count the hold while the button was down, restart it on the press edge
		for (b = 0; b < NUM_BTN; b++) begin
			was_down = !panel_prev[b];
			now_down = !t.levels[b];
			if (was_down && hold_ticks[b] != HOLD_MAX)
				hold_ticks[b]++;
			if (now_down && !was_down)
				hold_ticks[b] = '0;
			released[b] = was_down && !now_down;
		end
		// fixed order: remote, then screen, select and switch buttons
		if (t.remote_valid)
			run_command(t.remote_code, mask);
		if (released[BTN_SCREEN]) begin
			if (hold_ticks[BTN_SCREEN] > panel_cfg.hold_min &&
			    hold_ticks[BTN_SCREEN] < panel_cfg.long_hold)
				run_command(CMD_SCREEN, mask);
			else if (hold_ticks[BTN_SCREEN] > panel_cfg.long_hold)
				run_command(CMD_AUTO, mask);
		end
		if (released[BTN_SELECT] && hold_ticks[BTN_SELECT] > panel_cfg.hold_min &&
		    hold_ticks[BTN_SELECT] < panel_cfg.long_hold)
			run_command(CMD_SELECT, mask);
		if (released[BTN_SWITCH] && hold_ticks[BTN_SWITCH] > panel_cfg.hold_min)
			run_command(CMD_SWITCH, mask);
		if (buzz_lv && buzz_age > panel_cfg.buzzer_len)
			buzz_lv = 1'b0;
		panel_prev = t.levels;

		r.screen_mode    = flag_screen;
		r.auto_mode      = flag_auto;
		r.selected_relay = flag_select;
		r.relay_one      = relay_lv[0];
		r.relay_two      = relay_lv[1];
		r.lamp_one       = lamp_lv[0];
		r.lamp_two       = lamp_lv[1];
		r.buzzer_on      = buzz_lv;
		r.cmd_mask       = mask;
	endtask

	// ------------------------------------------------------------------
	// Monitors: predict on every input transfer, check every result transfer
	// ------------------------------------------------------------------

	always @(posedge clk) begin : tick_monitor
		tick_t   seen;
		result_t r;
		if (arst_n && in_valid && !in_stall) begin
			seen.levels[BTN_SCREEN] = btn_screen_level;
			seen.levels[BTN_SELECT] = btn_select_level;
			seen.levels[BTN_SWITCH] = btn_switch_level;
			seen.remote_valid       = remote_valid;
			seen.remote_code        = remote_button;
			advance_panel(seen, r);
			predicted_panel.push_back(r);
		end
	end

	// track register writes so the predictor decodes with the same thresholds
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HOLD_MIN:   panel_cfg.hold_min   = cfg_data;
				REG_LONG_HOLD:  panel_cfg.long_hold  = cfg_data;
				REG_BUZZER_LEN: panel_cfg.buzzer_len = cfg_data;
				default: ;
			endcase
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_panel.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual mask %0d buzzer %0d",
					$time, cmd_mask, buzzer_on);
				mismatches++;
			end else begin
				want = predicted_panel.pop_front();
				check_field("screen_mode", 32'(want.screen_mode), 32'(screen_mode));
				check_field("auto_mode", 32'(want.auto_mode), 32'(auto_mode));
				check_field("selected_relay", 32'(want.selected_relay), 32'(selected_relay));
				check_field("relay_one", 32'(want.relay_one), 32'(relay_one));
				check_field("relay_two", 32'(want.relay_two), 32'(relay_two));
				check_field("lamp_one", 32'(want.lamp_one), 32'(lamp_one));
				check_field("lamp_two", 32'(want.lamp_two), 32'(lamp_two));
				check_field("buzzer_on", 32'(want.buzzer_on), 32'(buzzer_on));
				check_field("cmd_mask", 32'(want.cmd_mask), 32'(cmd_mask));
			end
		end
	end

	// ------------------------------------------------------------------
	// Result sink: random stalls, or one long hold-off on request
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		// mostly short gaps, now and then a long one
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req > 0) begin
				stall_left    = sink_hold_req;
				sink_hold_req = 0;
			end else if (stall_left == 0 && sink_jitter && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			// one assignment per falling edge keeps the stall glitch-free
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if no transfer of any kind happens for too long
	// ------------------------------------------------------------------

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------

	// Offer one tick and hold it until the transfer; leave valid high for the next one.
	task automatic send_tick(input tick_t t);
		if (src_jitter && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
		btn_screen_level <= t.levels[BTN_SCREEN];
		btn_select_level <= t.levels[BTN_SELECT];
		btn_switch_level <= t.levels[BTN_SWITCH];
		remote_valid     <= t.remote_valid;
		remote_button    <= t.remote_code;
		in_valid         <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted result has come back, then let the
	// two-stage pipe settle.
	task automatic drain_results;
		in_valid <= 1'b0;
		while (predicted_panel.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all three registers while the panel is idle, preceded by a write to the
	// unused index that must be dropped.
	task automatic program_regs(input logic [CFG_W-1:0] hmin, input logic [CFG_W-1:0] lhold,
	                            input logic [CFG_W-1:0] blen);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_W-1:0]     val [4];
		int                   k;
		drain_results();
		idx[0] = REG_UNUSED;     val[0] = CFG_W'($urandom);
		idx[1] = REG_HOLD_MIN;   val[1] = hmin;
		idx[2] = REG_LONG_HOLD;  val[2] = lhold;
		idx[3] = REG_BUZZER_LEN; val[3] = blen;
		for (k = 0; k < 4; k++) begin
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Hold the given buttons down for ticks_down ticks, then release all with an optional
	// remote command on the release tick.
	task automatic press_release(input logic [NUM_BTN-1:0] held, input int ticks_down,
	                             input logic rv, input logic [CODE_W-1:0] code);
		tick_t t;
		int    k;
		t.remote_valid = 1'b0;
		for (k = 0; k < ticks_down; k++) begin
			t.levels      = ~held;
			t.remote_code = CODE_W'($urandom);
			send_tick(t);
		end
		t.levels       = '1;
		t.remote_valid = rv;
		t.remote_code  = code;
		send_tick(t);
	endtask

	task automatic idle_ticks(input int n);
		press_release('0, n - 1, 1'b0, CODE_NONE);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values and the reset thresholds: a short press below 1000 ticks does nothing,
	// a remote command starts the long default buzzer pulse.
	task automatic test_power_up;
		idle_ticks(3);
		press_release('0, 0, 1'b1, CMD_SCREEN);
		idle_ticks(4);
		press_release(HOLD_SCREEN | HOLD_SWITCH, 4, 1'b0, CODE_NONE);
	endtask

	// Hold windows with small thresholds: equal to hold_min or long_hold gives nothing,
	// between gives a short press, above long_hold a long press on the screen button.
	task automatic test_press_windows;
		program_regs(16'd1, 16'd3, 16'd2);
		press_release(HOLD_SCREEN, 1, 1'b0, CODE_NONE);
		press_release(HOLD_SCREEN, 2, 1'b0, CODE_NONE);
		press_release(HOLD_SCREEN, 3, 1'b0, CODE_NONE);
		press_release(HOLD_SCREEN, 4, 1'b0, CODE_NONE);
		press_release(HOLD_SELECT, 1, 1'b0, CODE_NONE);
		press_release(HOLD_SELECT, 2, 1'b0, CODE_NONE);
		press_release(HOLD_SELECT, 3, 1'b0, CODE_NONE);
		press_release(HOLD_SWITCH, 1, 1'b0, CODE_NONE);
		press_release(HOLD_SWITCH, 5, 1'b0, CODE_NONE);
	endtask

	// Every remote code once, plus a code offered with remote_valid low that must be ignored.
	task automatic test_remote_codes;
		tick_t t;
		int    c;
		t.levels       = '1;
		t.remote_valid = 1'b0;
		t.remote_code  = CMD_SWITCH;
		send_tick(t);
		for (c = 0; c < (1 << CODE_W); c++) begin
			t.remote_valid = 1'b1;
			t.remote_code  = CODE_W'(c);
			send_tick(t);
		end
	endtask

	// Remote and buttons on the same tick: doubled commands toggle twice and mark once,
	// and the select toggle lands before the relay switch.
	task automatic test_same_tick;
		program_regs(16'd1, 16'd3, 16'd0);
		press_release(HOLD_SCREEN, 2, 1'b1, CMD_SCREEN);
		press_release(HOLD_SELECT | HOLD_SWITCH, 2, 1'b1, CMD_SELECT);
		press_release(HOLD_SWITCH, 2, 1'b1, CMD_SWITCH);
		press_release(HOLD_SCREEN | HOLD_SELECT | HOLD_SWITCH, 2, 1'b0, CODE_NONE);
		idle_ticks(2);
	endtask

	// Register extremes: zero thresholds, all-ones thresholds, and a wide window.
	task automatic test_threshold_extremes;
		program_regs(16'd0, 16'd0, 16'd0);
		press_release(HOLD_SCREEN, 1, 1'b0, CODE_NONE);
		press_release(HOLD_SELECT, 1, 1'b0, CODE_NONE);
		press_release(HOLD_SWITCH, 1, 1'b0, CODE_NONE);
		program_regs('1, '1, '1);
		press_release(HOLD_SCREEN | HOLD_SWITCH, 2, 1'b1, CODE_ODD);
		idle_ticks(3);
		program_regs(16'd0, '1, 16'd0);
		press_release(HOLD_SCREEN, 1, 1'b0, CODE_NONE);
		press_release(HOLD_SELECT, 1, 1'b0, CODE_NONE);
	endtask

	// Fill the pipe: the sink holds off for a long stretch while ticks keep coming,
	// so in_stall has to rise and hold the offered tick.
	task automatic test_backpressure;
		tick_t t;
		int    k;
		program_regs(16'd1, 16'd4, 16'd3);
		src_jitter    = 1'b0;
		sink_jitter   = 1'b0;
		sink_hold_req = 300;
		for (k = 0; k < 40; k++) begin
			t.levels       = NUM_BTN'($urandom);
			t.remote_valid = ($urandom_range(0, 4) == 0);
			t.remote_code  = CODE_W'($urandom);
			send_tick(t);
		end
		drain_results();
		src_jitter  = 1'b1;
		sink_jitter = 1'b1;
	endtask

	// Long presses under an all-ones long_hold land in the short window, and the buzzer
	// stays on with buzzer_len at all ones, still on after the limit drops below the top.
	task automatic test_long_hold;
		tick_t t;
		program_regs(16'd2, '1, '1);
		press_release('0, 0, 1'b1, CODE_ODD);
		press_release(HOLD_SCREEN | HOLD_SELECT, LONG_TICKS, 1'b0, CODE_NONE);
		program_regs(16'd2, '1, AGE_MAX - AGE_W'(1));
		t.levels       = '1;
		t.remote_valid = 1'b0;
		t.remote_code  = CODE_W'($urandom);
		send_tick(t);
	endtask

	// Random traffic in several register phases: overlapping presses of random length
	// around the thresholds, remote commands, and some raw level noise.
	task automatic test_random_traffic;
		int               left [NUM_BTN];
		int               phase;
		int               k;
		int               b;
		int               lim;
		logic [CFG_W-1:0] hmin;
		logic [CFG_W-1:0] lhold;
		tick_t            t;
		for (phase = 0; phase < 6; phase++) begin
			hmin  = CFG_W'($urandom_range(0, 4));
			lhold = CFG_W'($urandom_range(0, 8));
			program_regs(hmin, lhold, CFG_W'($urandom_range(0, 10)));
			lim = ((lhold > hmin) ? lhold : hmin) + 3;
			// first phase runs without idling on either side
			src_jitter  = (phase != 0);
			sink_jitter = (phase != 0);
			for (b = 0; b < NUM_BTN; b++)
				left[b] = 0;
			for (k = 0; k < 90; k++) begin
				for (b = 0; b < NUM_BTN; b++) begin
					if (left[b] > 0) begin
						t.levels[b] = 1'b0;
						left[b]--;
					end else begin
						t.levels[b] = 1'b1;
						if ($urandom_range(0, 5) == 0)
							left[b] = $urandom_range(1, lim);
					end
				end
				if ($urandom_range(0, 11) == 0)
					t.levels = NUM_BTN'($urandom);
				t.remote_valid = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 3) == 0)
					t.remote_code = CODE_W'($urandom);
				else
					t.remote_code = CODE_W'($urandom_range(CMD_SCREEN, CMD_SWITCH));
				send_tick(t);
				// pause the sender once until the pipe is empty
				if (phase == 2 && k == 45)
					drain_results();
			end
		end
		src_jitter  = 1'b1;
		sink_jitter = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		// drive every input to a known value before reset releases
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		btn_screen_level = 1'b1;
		btn_select_level = 1'b1;
		btn_switch_level = 1'b1;
		remote_valid     = 1'b0;
		remote_button    = CODE_NONE;
		cfg_valid        = 1'b0;
		cfg_index        = REG_HOLD_MIN;
		cfg_data         = '0;
		reset_panel_model();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_power_up();
		test_press_windows();
		test_remote_codes();
		test_same_tick();
		test_threshold_extremes();
		test_backpressure();
		test_long_hold();
		test_random_traffic();

		// hold until every predicted result has been checked
		drain_results();
		if (mismatches == 0 && predicted_panel.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
